### hw/rtl/smr_pkg.sv
`timescale 1ns / 1ps
// smr_pkg: shared types, constants and helpers for the spiral order matrix reader
// no dependencies

package smr_pkg;

  // matrix geometry limits
  localparam int MAX_ROWS    = 16;
  localparam int MAX_COLUMNS = 16;
  localparam int MAX_DIM     = (MAX_ROWS > MAX_COLUMNS) ? MAX_ROWS : MAX_COLUMNS;
  localparam int STORE_DEPTH = MAX_ROWS * MAX_COLUMNS;

  // widths
  localparam int DATA_W    = 32;
  localparam int DIM_W     = 5;                       // configuration register width
  localparam int DIMV_W    = $clog2(MAX_DIM + 1);     // effective row / column count
  localparam int POS_W     = DIMV_W + 1;              // signed walk position and bound
  localparam int ADDR_W    = $clog2(STORE_DEPTH);
  localparam int CNT_W     = $clog2(STORE_DEPTH + 1); // element counts up to the depth
  localparam int CFG_IDX_W = 1;

  localparam logic signed [POS_W-1:0] POS_ONE = POS_W'(1);

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_READ = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_COUNT    = 1'b0,
    REG_COLUMN_COUNT = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    DIR_RIGHT = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_UP    = 2'd3
  } dir_e;

  // effective matrix shape
  typedef struct packed {
    logic [DIMV_W-1:0] rows;
    logic [DIMV_W-1:0] cols;
    logic [CNT_W-1:0]  total;
  } dims_t;

  // commands to the walk unit
  typedef struct packed {
    logic restart;
    logic step;
  } walk_ctl_t;

  // walk unit status for the current position
  typedef struct packed {
    logic              hit;
    logic              last;
    logic [ADDR_W-1:0] addr;
  } walk_stat_t;

  // zero counts as one, anything above the limit counts as the limit
  function automatic logic [DIMV_W-1:0] clamp_dim(input logic [DIM_W-1:0] raw,
                                                  input int unsigned limit);
    logic [DIMV_W-1:0] res;
    if (raw == '0) begin
      res = DIMV_W'(1);
    end else if (32'(raw) > limit) begin
      res = DIMV_W'(limit);
    end else begin
      res = DIMV_W'(raw);
    end
    return res;
  endfunction

endpackage

### hw/rtl/smr_if.sv
`timescale 1ns / 1ps
// smr_in_if, smr_out_if, smr_cfg_if: valid / ready channels of the spiral reader
// depends on smr_pkg

// input item channel
interface smr_in_if import smr_pkg::*; ();
  logic                     valid;
  logic                     ready;
  op_e                      operation;
  logic signed [DATA_W-1:0] element_value;

  modport source (output valid, output operation, output element_value, input ready);
  modport sink   (input valid, input operation, input element_value, output ready);
endinterface

// result channel
interface smr_out_if import smr_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] result_value;
  logic                     result_valid;
  logic                     is_last;

  modport source (output valid, output result_value, output result_valid,
                  output is_last, input ready);
  modport sink   (input valid, input result_value, input result_valid,
                  input is_last, output ready);
endinterface

// configuration write channel
interface smr_cfg_if import smr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DIM_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/smr_walk.sv
`timescale 1ns / 1ps
// smr_walk: spiral walk state (bounds, direction, position, emitted count)
// depends on smr_pkg

module smr_walk import smr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  dims_t      dims_i,
  input  walk_ctl_t  ctl_i,
  output walk_stat_t stat_o
);

  // bottom and right bounds are kept as offsets from the matrix edge
  logic signed [POS_W-1:0] top_q, top_d;
  logic signed [POS_W-1:0] boff_q, boff_d;
  logic signed [POS_W-1:0] left_q, left_d;
  logic signed [POS_W-1:0] roff_q, roff_d;
  logic signed [POS_W-1:0] row_q, row_d;
  logic signed [POS_W-1:0] col_q, col_d;
  dir_e                    dir_q, dir_d;
  logic [CNT_W-1:0]        emitted_q, emitted_d;

  logic signed [POS_W-1:0] rows_s, cols_s;
  logic [CNT_W-1:0]        emitted_inc;
  logic [CNT_W-1:0]        addr_prod;

  assign rows_s      = $signed({1'b0, dims_i.rows});
  assign cols_s      = $signed({1'b0, dims_i.cols});
  assign emitted_inc = emitted_q + CNT_W'(1);

  // status of the current position
  assign stat_o.hit  = (emitted_q < dims_i.total) && (row_q >= 0) && (col_q >= 0);
  assign stat_o.last = (emitted_inc == dims_i.total);
  assign addr_prod   = CNT_W'(row_q[POS_W-2:0]) * CNT_W'(dims_i.cols);
  assign stat_o.addr = ADDR_W'(addr_prod + CNT_W'(col_q[POS_W-2:0]));

  // next walk state
  always_comb begin
    logic signed [POS_W-1:0] bot;
    logic signed [POS_W-1:0] right;
    logic                    moved;
    logic                    found;
    top_d     = top_q;
    boff_d    = boff_q;
    left_d    = left_q;
    roff_d    = roff_q;
    row_d     = row_q;
    col_d     = col_q;
    dir_d     = dir_q;
    emitted_d = emitted_q;
    moved     = 1'b0;
    found     = 1'b0;
    bot       = rows_s - POS_ONE - boff_q;
    right     = cols_s - POS_ONE - roff_q;
    if (ctl_i.restart) begin
      top_d     = '0;
      boff_d    = '0;
      left_d    = '0;
      roff_d    = '0;
      row_d     = '0;
      col_d     = '0;
      dir_d     = DIR_RIGHT;
      emitted_d = '0;
    end else if (ctl_i.step && stat_o.hit) begin
      emitted_d = emitted_inc;
      if (!stat_o.last) begin
        // move along the current segment
        unique case (dir_q)
          DIR_RIGHT: if (col_q < right) begin col_d = col_q + POS_ONE; moved = 1'b1; end
          DIR_DOWN:  if (row_q < bot)   begin row_d = row_q + POS_ONE; moved = 1'b1; end
          DIR_LEFT:  if (col_q > left_q) begin col_d = col_q - POS_ONE; moved = 1'b1; end
          DIR_UP:    if (row_q > top_q) begin row_d = row_q - POS_ONE; moved = 1'b1; end
          default: ;
        endcase
        // segment done: shrink a bound and turn until a segment is non-empty
        if (!moved) begin
          for (int k = 0; k < 4; k++) begin
            if (!found) begin
              case (dir_d)
                DIR_RIGHT: top_d  = top_d + POS_ONE;
                DIR_DOWN:  roff_d = roff_d + POS_ONE;
                DIR_LEFT:  boff_d = boff_d + POS_ONE;
                default:   left_d = left_d + POS_ONE;
              endcase
              dir_d = dir_e'(2'(dir_d + 2'd1));
              bot   = rows_s - POS_ONE - boff_d;
              right = cols_s - POS_ONE - roff_d;
              case (dir_d)
                DIR_RIGHT: begin row_d = top_d; col_d = left_d; end
                DIR_DOWN:  begin row_d = top_d; col_d = right;  end
                DIR_LEFT:  begin row_d = bot;   col_d = right;  end
                default:   begin row_d = bot;   col_d = left_d; end
              endcase
              found = (top_d <= bot) && (left_d <= right);
            end
          end
        end
      end
    end
  end

  // walk registers, reset to the start of a fresh walk
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q     <= '0;
      boff_q    <= '0;
      left_q    <= '0;
      roff_q    <= '0;
      row_q     <= '0;
      col_q     <= '0;
      dir_q     <= DIR_RIGHT;
      emitted_q <= '0;
    end else begin
      top_q     <= top_d;
      boff_q    <= boff_d;
      left_q    <= left_d;
      roff_q    <= roff_d;
      row_q     <= row_d;
      col_q     <= col_d;
      dir_q     <= dir_d;
      emitted_q <= emitted_d;
    end
  end

  // a hit always points inside the matrix
  a_hit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.hit |-> (row_q < rows_s) && (col_q < cols_s))
    else $error("walk position outside the matrix");

  // emitted count never passes the element total
  a_emitted_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emitted_q <= dims_i.total)
    else $error("emitted count beyond element total");

  // after the last element the walk stays finished
  a_end_of_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.step && stat_o.hit && stat_o.last && !ctl_i.restart |=> !stat_o.hit)
    else $error("walk continued past the last element");

endmodule

### hw/rtl/spiral_order_matrix_reader_core.sv
`timescale 1ns / 1ps
// spiral_order_matrix_reader_core: top level, matrix store, load pointer, result register
// depends on smr_pkg, smr_if (smr_in_if, smr_out_if, smr_cfg_if), smr_walk
//
//   channel  dir  beat carries                              result
//   cfg_i    in   index, data (row / column count)          none
//   in_i     in   operation, element_value                  one beat per read, none per load
//   out_o    out  result_value, result_valid, is_last       -
//
// one item per cycle while in_i.ready is high; a read beat addresses the store at
// acceptance and its result sits in the output register in the next cycle
// in_i.ready drops only while a result sits in the output register and out_o.ready is low
// cfg_i.ready is always high; a write restarts the walk and the load pointer
// reset: 4 x 4 matrix, fresh walk; store contents undefined, no clearing pass

module spiral_order_matrix_reader_core import smr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  smr_cfg_if.sink   cfg_i,
  smr_in_if.sink    in_i,
  smr_out_if.source out_o
);

  logic [DIM_W-1:0]  row_cnt_q, col_cnt_q;
  logic [CNT_W-1:0]  load_pos_q, load_pos_d;
  logic [CNT_W-1:0]  wr_pos;
  logic              pend_q, res_valid_q, res_last_q;
  logic [DATA_W-1:0] rdata_q;
  logic [DATA_W-1:0] store_mem [STORE_DEPTH];

  logic       cfg_acc, in_acc, load_acc, read_acc;
  dims_t      dims;
  walk_ctl_t  walk_ctl;
  walk_stat_t walk_stat;

  // handshakes
  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = !pend_q || out_o.ready;
  assign cfg_acc     = cfg_i.valid && cfg_i.ready;
  assign in_acc      = in_i.valid && in_i.ready;
  assign load_acc    = in_acc && (in_i.operation == OP_LOAD);
  assign read_acc    = in_acc && (in_i.operation == OP_READ);

  // effective matrix shape
  assign dims.rows  = clamp_dim(row_cnt_q, MAX_ROWS);
  assign dims.cols  = clamp_dim(col_cnt_q, MAX_COLUMNS);
  assign dims.total = CNT_W'(dims.rows) * CNT_W'(dims.cols);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cnt_q <= DIM_W'(4);
      col_cnt_q <= DIM_W'(4);
    end else if (cfg_acc) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_ROW_COUNT:    row_cnt_q <= cfg_i.data;
        REG_COLUMN_COUNT: col_cnt_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // row-major load pointer, wraps once the matrix is full
  assign wr_pos = (load_pos_q >= dims.total) ? '0 : load_pos_q;

  always_comb begin
    load_pos_d = load_pos_q;
    if (cfg_acc) begin
      load_pos_d = '0;
    end else if (load_acc) begin
      load_pos_d = wr_pos + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_pos_q <= '0;
    end else begin
      load_pos_q <= load_pos_d;
    end
  end

  // spiral walk
  assign walk_ctl.restart = cfg_acc || load_acc;
  assign walk_ctl.step    = read_acc;

  smr_walk u_walk (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .dims_i (dims),
    .ctl_i  (walk_ctl),
    .stat_o (walk_stat)
  );

  // matrix store: one write port for loads, one registered read port for the walk;
  // a read is always accepted after its load, never in the same beat, so no forwarding is needed
  always_ff @(posedge clk_i) begin
    if (load_acc) begin
      store_mem[wr_pos[ADDR_W-1:0]] <= in_i.element_value;
    end
    if (read_acc && walk_stat.hit) begin
      rdata_q <= store_mem[walk_stat.addr];
    end
  end

  // output register flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      res_valid_q <= 1'b0;
      res_last_q  <= 1'b0;
    end else if (read_acc) begin
      pend_q      <= 1'b1;
      res_valid_q <= walk_stat.hit;
      res_last_q  <= walk_stat.hit && walk_stat.last;
    end else if (out_o.ready) begin
      pend_q      <= 1'b0;
    end
  end

  // result beat
  assign out_o.valid        = pend_q;
  assign out_o.result_value = res_valid_q ? rdata_q : '0;
  assign out_o.result_valid = res_valid_q;
  assign out_o.is_last      = res_last_q;

  // load pointer never runs past the element total
  a_load_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_pos_q <= dims.total)
    else $error("load pointer beyond element total");

  // a finished walk result never carries the last flag
  a_last_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    read_acc && !walk_stat.hit |=> pend_q && !res_valid_q && !res_last_q)
    else $error("empty read produced a flagged result");

  // a stalled result keeps its flags
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q && !out_o.ready |=> pend_q && $stable(res_valid_q) && $stable(res_last_q))
    else $error("stalled result changed");

endmodule
